// ===== design/skmt_pkg.sv =====
// ----------------------------------------------------------------------------
// skmt_pkg
// Shared constants and types of the scan code modifier tracker: ring size,
// set 1 key codes, flag bit masks and the status groups between modules.
// ----------------------------------------------------------------------------
package skmt_pkg;

  // Ring of buffered make codes (one slot stays free to tell full from empty)
  localparam int unsigned RingDepth = 128;
  localparam int unsigned RingAw    = (RingDepth > 1) ? $clog2(RingDepth) : 1;

  // Operation codes of an input transaction
  localparam logic OpArrive = 1'b0;
  localparam logic OpPop    = 1'b1;

  // Set 1 key codes, bit 7 (break) removed
  localparam logic [6:0] ScLshift = 7'h2A;
  localparam logic [6:0] ScRshift = 7'h36;
  localparam logic [6:0] ScLctrl  = 7'h1D;
  localparam logic [6:0] ScLalt   = 7'h38;
  localparam logic [6:0] ScScroll = 7'h46;
  localparam logic [6:0] ScNum    = 7'h45;
  localparam logic [6:0] ScCaps   = 7'h3A;
  localparam logic [6:0] ScInsert = 7'h52;

  // Main flag byte bits
  localparam logic [7:0] MainRshift = 8'h01;
  localparam logic [7:0] MainLshift = 8'h02;
  localparam logic [7:0] MainCtrl   = 8'h04;
  localparam logic [7:0] MainAlt    = 8'h08;
  localparam logic [7:0] MainScroll = 8'h10;
  localparam logic [7:0] MainNum    = 8'h20;
  localparam logic [7:0] MainCaps   = 8'h40;
  localparam logic [7:0] MainInsert = 8'h80;

  // Held flag byte bits
  localparam logic [7:0] HeldLctrl  = 8'h01;
  localparam logic [7:0] HeldLalt   = 8'h02;
  localparam logic [7:0] HeldScroll = 8'h10;
  localparam logic [7:0] HeldNum    = 8'h20;
  localparam logic [7:0] HeldCaps   = 8'h40;

  // Flag state after the latest transaction
  typedef struct packed {
    logic [7:0] main_flags;
    logic [7:0] held_flags;
    logic       led_update;
  } flag_stat_t;

  // Ring state after the latest transaction
  typedef struct packed {
    logic [7:0] rd_data;
    logic       pop_hit;
    logic       empty;
    logic       dropped;
  } ring_stat_t;

endpackage

// ===== design/skmt_if.sv =====
// ----------------------------------------------------------------------------
// skmt_in_if / skmt_out_if
// Valid/ready channels of the tracker: scan code or pop request in, one
// result transaction out.
// ----------------------------------------------------------------------------
interface skmt_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] code_byte;

  modport source (output valid, output operation, output code_byte, input ready);
  modport sink   (input valid, input operation, input code_byte, output ready);
endinterface

interface skmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] shift_flags;
  logic [7:0] pressed_flags;
  logic       led_update;
  logic [2:0] led_bits;
  logic       buffer_empty;
  logic       dropped;

  modport source (output valid, output data_byte, output shift_flags,
                  output pressed_flags, output led_update, output led_bits,
                  output buffer_empty, output dropped, input ready);
  modport sink   (input valid, input data_byte, input shift_flags,
                  input pressed_flags, input led_update, input led_bits,
                  input buffer_empty, input dropped, output ready);
endinterface

// ===== design/skmt_ram.sv =====
// ----------------------------------------------------------------------------
// skmt_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module skmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/skmt_flags.sv =====
// ----------------------------------------------------------------------------
// skmt_flags
// Shift state tracker: updates the main and held flag bytes from arriving
// set 1 make and break codes and flags lock key presses for an LED resend.
// ----------------------------------------------------------------------------
module skmt_flags (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                pop_i,
  input  logic [7:0]          code_i,
  output skmt_pkg::flag_stat_t stat_o
);

  logic [7:0] main_q, main_d;
  logic [7:0] held_q, held_d;
  logic       led_q, led_d;

  // Apply one scan code to the flag bytes
  always_comb begin
    main_d = main_q;
    held_d = held_q;
    led_d  = 1'b0;
    if (code_i[7]) begin
      // break: release held bits
      case (code_i[6:0])
        skmt_pkg::ScLshift: main_d = main_q & ~skmt_pkg::MainLshift;
        skmt_pkg::ScRshift: main_d = main_q & ~skmt_pkg::MainRshift;
        skmt_pkg::ScLctrl: begin
          main_d = main_q & ~skmt_pkg::MainCtrl;
          held_d = held_q & ~skmt_pkg::HeldLctrl;
        end
        skmt_pkg::ScLalt: begin
          main_d = main_q & ~skmt_pkg::MainAlt;
          held_d = held_q & ~skmt_pkg::HeldLalt;
        end
        skmt_pkg::ScScroll: held_d = held_q & ~skmt_pkg::HeldScroll;
        skmt_pkg::ScNum:    held_d = held_q & ~skmt_pkg::HeldNum;
        skmt_pkg::ScCaps:   held_d = held_q & ~skmt_pkg::HeldCaps;
        default: ;
      endcase
    end else begin
      // make: set held bits, toggle locks and insert
      case (code_i[6:0])
        skmt_pkg::ScLshift: main_d = main_q | skmt_pkg::MainLshift;
        skmt_pkg::ScRshift: main_d = main_q | skmt_pkg::MainRshift;
        skmt_pkg::ScLctrl: begin
          main_d = main_q | skmt_pkg::MainCtrl;
          held_d = held_q | skmt_pkg::HeldLctrl;
        end
        skmt_pkg::ScLalt: begin
          main_d = main_q | skmt_pkg::MainAlt;
          held_d = held_q | skmt_pkg::HeldLalt;
        end
        skmt_pkg::ScScroll: begin
          main_d = main_q ^ skmt_pkg::MainScroll;
          held_d = held_q | skmt_pkg::HeldScroll;
          led_d  = 1'b1;
        end
        skmt_pkg::ScNum: begin
          main_d = main_q ^ skmt_pkg::MainNum;
          held_d = held_q | skmt_pkg::HeldNum;
          led_d  = 1'b1;
        end
        skmt_pkg::ScCaps: begin
          main_d = main_q ^ skmt_pkg::MainCaps;
          held_d = held_q | skmt_pkg::HeldCaps;
          led_d  = 1'b1;
        end
        skmt_pkg::ScInsert: main_d = main_q ^ skmt_pkg::MainInsert;
        default: ;
      endcase
    end
  end

  // Hold flag state; a pop transaction clears only the LED request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q <= '0;
      held_q <= '0;
      led_q  <= 1'b0;
    end else if (step_i) begin
      main_q <= main_d;
      held_q <= held_d;
      led_q  <= led_d;
    end else if (pop_i) begin
      led_q  <= 1'b0;
    end
  end

  assign stat_o.main_flags = main_q;
  assign stat_o.held_flags = held_q;
  assign stat_o.led_update = led_q;

endmodule

// ===== design/skmt_ring.sv =====
// ----------------------------------------------------------------------------
// skmt_ring
// Ring buffer of make codes: write and read slots around one RAM, full and
// empty detection, drop of pushes to a full ring and empty pops.
// ----------------------------------------------------------------------------
module skmt_ring (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  logic [7:0]           code_i,
  output skmt_pkg::ring_stat_t stat_o
);

  localparam int unsigned Aw = skmt_pkg::RingAw;
  localparam logic [Aw-1:0] LastSlot = Aw'(skmt_pkg::RingDepth - 1);

  logic [Aw-1:0] wr_q, wr_d, wr_nxt;
  logic [Aw-1:0] rd_q, rd_d, rd_nxt;
  logic          full, empty;
  logic          do_write, do_read;
  logic          hit_q, drop_q;
  logic [7:0]    rdata;

  // Advance a slot with wrap at the ring end
  assign wr_nxt = (wr_q == LastSlot) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == LastSlot) ? '0 : rd_q + 1'b1;

  assign empty    = (wr_q == rd_q);
  assign full     = (wr_nxt == rd_q);
  assign do_write = push_i & ~full;
  assign do_read  = pop_i & ~empty;

  assign wr_d = do_write ? wr_nxt : wr_q;
  assign rd_d = do_read ? rd_nxt : rd_q;

  // Hold slots and the per-transaction status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      hit_q  <= 1'b0;
      drop_q <= 1'b0;
    end else if (step_i) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      hit_q  <= do_read;
      drop_q <= push_i & full;
    end
  end

  // Code storage; a write is visible to a read in the next cycle
  skmt_ram #(
    .Width (8),
    .Depth (skmt_pkg::RingDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_q),
    .wdata_i (code_i),
    .re_i    (do_read),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  assign stat_o.rd_data = rdata;
  assign stat_o.pop_hit = hit_q;
  assign stat_o.empty   = (wr_q == rd_q);
  assign stat_o.dropped = drop_q;

endmodule

// ===== design/scancode_modifier_tracker_fifo.sv =====
// A result is offered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the input is taken whenever the
// output register is empty or being drained.
// Reset clears the flag bytes and ring slots; ring contents stay undefined
// and are never read before being written.
// ----------------------------------------------------------------------------
// scancode_modifier_tracker_fifo
// Keyboard shift state tracker for scan code set 1 with a buffer of make
// codes, popped on request.
// ----------------------------------------------------------------------------
module scancode_modifier_tracker_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  skmt_in_if.sink           in_i,
  skmt_out_if.source        out_o
);

  logic                 accept;
  logic                 step_code;
  logic                 push;
  logic                 pop;
  logic                 out_valid_q;
  logic [7:0]           code_q;
  skmt_pkg::flag_stat_t flag_stat;
  skmt_pkg::ring_stat_t ring_stat;

  // Take a new transaction when the output register frees up
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign step_code  = accept & (in_i.operation == skmt_pkg::OpArrive);
  assign push       = step_code & ~in_i.code_byte[7];
  assign pop        = accept & (in_i.operation == skmt_pkg::OpPop);

  skmt_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_code),
    .pop_i  (pop),
    .code_i (in_i.code_byte),
    .stat_o (flag_stat)
  );

  skmt_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .push_i (push),
    .pop_i  (pop),
    .code_i (in_i.code_byte),
    .stat_o (ring_stat)
  );

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Echoed code, zero for a pop
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q <= (in_i.operation == skmt_pkg::OpArrive) ? in_i.code_byte : 8'h00;
    end
  end

  // Drive the result transaction
  assign out_o.valid         = out_valid_q;
  assign out_o.data_byte     = ring_stat.pop_hit ? ring_stat.rd_data : code_q;
  assign out_o.shift_flags   = flag_stat.main_flags;
  assign out_o.pressed_flags = flag_stat.held_flags;
  assign out_o.led_update    = flag_stat.led_update;
  assign out_o.led_bits      = flag_stat.main_flags[6:4];
  assign out_o.buffer_empty  = ring_stat.empty;
  assign out_o.dropped       = ring_stat.dropped;

endmodule
